// ===== rtl/rdsf_pkg.sv =====
// ----------------------------------------------------------------------------
// rdsf_pkg
// Shared types and constants of the radial distortion scatter-fill core:
// transfer payloads, request and register codes, and the control states.
// ----------------------------------------------------------------------------
package rdsf_pkg;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       last_pixel;
    } out_item_t;

    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_LOAD   = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Q4  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B     = 3'd4;

    localparam int MUL_W   = 64;
    localparam int PROD_W  = 128;
    localparam int DIGIT_W = 16;

    localparam int PIX_W = 24;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_L_SQ,
        ST_L_SQ2,
        ST_L_MGO,
        ST_L_MWAIT,
        ST_L_WR,
        ST_R_CTR,
        ST_R_CTRW,
        ST_R_NB,
        ST_R_NBW,
        ST_R_FILL,
        ST_R_OUT
    } state_t;

endpackage

// ===== rtl/rdsf_mul.sv =====
// ----------------------------------------------------------------------------
// rdsf_mul
// Sequential signed 64 x 64 multiplier, product kept modulo 2^128.
// One 16-bit digit of b is taken per cycle; done pulses after four steps.
// ----------------------------------------------------------------------------
module rdsf_mul (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [rdsf_pkg::MUL_W-1:0]   op_a,
    input  logic [rdsf_pkg::MUL_W-1:0]   op_b,
    output logic                         done,
    output logic [rdsf_pkg::PROD_W-1:0]  prod
);
    import rdsf_pkg::*;

    localparam int STEPS  = MUL_W / DIGIT_W;
    localparam int STEP_W = $clog2(STEPS);
    localparam int PP_W   = MUL_W + DIGIT_W + 1;

    logic                      busy_reg;
    logic                      done_reg;
    logic [STEP_W-1:0]         step_reg;
    logic signed [MUL_W-1:0]   a_reg;
    logic [MUL_W-1:0]          b_reg;
    logic [PROD_W-1:0]         acc_reg;

    logic [DIGIT_W-1:0]        digit;
    logic signed [DIGIT_W:0]   digit_ext;
    logic signed [PP_W-1:0]    pp;
    logic [PROD_W-1:0]         pp_shifted;

    always_comb begin
        digit = b_reg[step_reg*DIGIT_W +: DIGIT_W];
        // Only the top digit carries the sign of b.
        digit_ext = (step_reg == STEP_W'(STEPS - 1)) ? {digit[DIGIT_W-1], digit}
                                                      : {1'b0, digit};
        pp = a_reg * digit_ext;
        pp_shifted = PROD_W'(pp) << (32'(step_reg) * DIGIT_W);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= $signed(op_a);
            b_reg   <= op_b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_reg + pp_shifted;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== rtl/rdsf_store.sv =====
// ----------------------------------------------------------------------------
// rdsf_store
// Frame store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rdsf_store #(
    parameter int DEPTH = 262144,
    parameter int AW    = 18
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [rdsf_pkg::PIX_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [rdsf_pkg::PIX_W-1:0] rd_data
);
    import rdsf_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/radial_distortion_scatter_fill_core.sv =====
// ----------------------------------------------------------------------------
// radial_distortion_scatter_fill_core
// Frame store with radial distortion scatter on load and hole repair on read.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                       Direction  Carries
//  input    s_valid s_ready s_data      in         clear, load or read request
//  result   m_valid m_ready m_data      out        one repaired pixel per read
//  config   cfg_wr_en cfg_index ...     in         register writes, no wait
//
// A load takes the accepting cycle, two squaring stages, then four passes
// through the shared sequential multiplier (four 16-bit digit steps each),
// then the store write. A read fetches the pixel; for a black pixel each of
// its four neighbors inside the frame is then read in turn before the repair.
// A clear request, and the pass that follows reset, write zeros to
// MAX_ROWS * 2^ceil(log2(MAX_COLS)) store entries, one per cycle, with
// s_ready low; configuration writes are taken throughout.
// A finished pixel waits in the output register; the next request is accepted
// meanwhile, and a later read waits only while that register is still full.
// ----------------------------------------------------------------------------
module radial_distortion_scatter_fill_core #(
    parameter int MAX_ROWS = 512,
    parameter int MAX_COLS = 512
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rdsf_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rdsf_pkg::out_item_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [rdsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rdsf_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
    import rdsf_pkg::*;

    localparam int RA    = $clog2(MAX_ROWS);
    localparam int CA    = $clog2(MAX_COLS);
    localparam int RN    = $clog2(MAX_ROWS + 1);
    localparam int CN    = $clog2(MAX_COLS + 1);
    localparam int AW    = RA + CA;
    localparam int DEPTH = MAX_ROWS * (2 ** CA);
    localparam int XYW   = ((RA > CA) ? RA : CA) + 2;
    localparam int D2W   = 2 * XYW;

    // floor(v / 6) for v below 2048 is (v * 2731) >> 14.
    localparam int RECIP_DIV6 = 2731;
    localparam int SHIFT_DIV6 = 14;

    // Configuration registers.
    logic [9:0]         frame_rows_reg;
    logic [9:0]         frame_cols_reg;
    logic [13:0]        radius_reg;
    logic signed [39:0] coef_a_reg;
    logic signed [47:0] coef_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_rows_reg <= 10'd512;
            frame_cols_reg <= 10'd512;
            radius_reg     <= '0;
            coef_a_reg     <= '0;
            coef_b_reg     <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FRAME_ROWS: frame_rows_reg <= cfg_wr_data[9:0];
                CFG_FRAME_COLS: frame_cols_reg <= cfg_wr_data[9:0];
                CFG_RADIUS_Q4:  radius_reg     <= cfg_wr_data[13:0];
                CFG_COEF_A:     coef_a_reg     <= $signed(cfg_wr_data[39:0]);
                CFG_COEF_B:     coef_b_reg     <= $signed(cfg_wr_data[47:0]);
                default: ;
            endcase
        end
    end

    // Frame size in use, clamped to 1 .. MAX.
    logic [RN-1:0] rows_eff;
    logic [CN-1:0] cols_eff;

    always_comb begin
        if (frame_rows_reg == 10'd0) begin
            rows_eff = RN'(1);
        end else if (32'(frame_rows_reg) > MAX_ROWS) begin
            rows_eff = RN'(MAX_ROWS);
        end else begin
            rows_eff = RN'(frame_rows_reg);
        end
        if (frame_cols_reg == 10'd0) begin
            cols_eff = CN'(1);
        end else if (32'(frame_cols_reg) > MAX_COLS) begin
            cols_eff = CN'(MAX_COLS);
        end else begin
            cols_eff = CN'(frame_cols_reg);
        end
    end

    // Control state and datapath registers.
    state_t state_reg, state_next;

    logic [AW-1:0]     clr_addr_reg;
    logic [RA-1:0]     load_row_reg, read_row_reg, cur_row_reg;
    logic [CA-1:0]     load_col_reg, read_col_reg, cur_col_reg;
    logic              cur_last_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic [1:0]        op_reg;
    logic [1:0]        nb_reg;
    logic [MUL_W-1:0]  x64_reg, y64_reg;
    logic [D2W-1:0]    d2_reg;
    logic [27:0]       r2_reg;
    logic [MUL_W-1:0]  dd2_reg, dd4_reg;
    logic [PROD_W-1:0] ta_reg;
    logic [MUL_W-1:0]  cq_reg;
    logic              tr_ok_reg, tc_ok_reg;
    logic [RA-1:0]     tr_reg;
    logic [CA-1:0]     tc_reg;
    logic [9:0]        sum_b_reg, sum_g_reg, sum_r_reg;
    logic [2:0]        nb_cnt_reg;
    logic [PIX_W-1:0]  res_px_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    // Counters brought back to the origin when a frame size change left them
    // outside the frame.
    logic [RA-1:0] lrow_n, rrow_n, lrow_adv, rrow_adv;
    logic [CA-1:0] lcol_n, rcol_n, lcol_adv, rcol_adv;
    logic [CN-1:0] lcol_inc, rcol_inc;
    logic [RN-1:0] lrow_inc, rrow_inc;
    logic          r_last;

    always_comb begin
        if (RN'(load_row_reg) >= rows_eff || CN'(load_col_reg) >= cols_eff) begin
            lrow_n = '0;
            lcol_n = '0;
        end else begin
            lrow_n = load_row_reg;
            lcol_n = load_col_reg;
        end
        if (RN'(read_row_reg) >= rows_eff || CN'(read_col_reg) >= cols_eff) begin
            rrow_n = '0;
            rcol_n = '0;
        end else begin
            rrow_n = read_row_reg;
            rcol_n = read_col_reg;
        end

        lcol_inc = CN'(lcol_n) + 1'b1;
        lrow_inc = RN'(lrow_n) + 1'b1;
        if (lcol_inc >= cols_eff) begin
            lcol_adv = '0;
            lrow_adv = (lrow_inc >= rows_eff) ? '0 : lrow_inc[RA-1:0];
        end else begin
            lcol_adv = lcol_inc[CA-1:0];
            lrow_adv = lrow_n;
        end

        rcol_inc = CN'(rcol_n) + 1'b1;
        rrow_inc = RN'(rrow_n) + 1'b1;
        if (rcol_inc >= cols_eff) begin
            rcol_adv = '0;
            rrow_adv = (rrow_inc >= rows_eff) ? '0 : rrow_inc[RA-1:0];
        end else begin
            rcol_adv = rcol_inc[CA-1:0];
            rrow_adv = rrow_n;
        end
        r_last = (rrow_inc == rows_eff) && (rcol_inc == cols_eff);
    end

    // Radial offset and squared distance of the pixel being loaded.
    logic signed [XYW-1:0]   x_s, y_s;
    logic signed [2*XYW-1:0] sqx, sqy;
    logic [27:0]             r2_c;
    logic [2*D2W-1:0]        d2sq;
    logic [55:0]             r4;

    always_comb begin
        x_s  = $signed(XYW'(cur_col_reg)) - $signed(XYW'(cols_eff >> 1));
        y_s  = $signed(XYW'(cur_row_reg)) - $signed(XYW'(rows_eff >> 1));
        sqx  = x_s * x_s;
        sqy  = y_s * y_s;
        r2_c = radius_reg * radius_reg;
        d2sq = d2_reg * d2_reg;
        r4   = r2_reg * r2_reg;
    end

    // Shared multiplier: A*D2, B*D4, then y*C and x*C.
    logic              mul_start;
    logic              mul_done;
    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] mul_prod;

    always_comb begin
        case (op_reg)
            2'd0: begin
                mul_a = MUL_W'(coef_a_reg);
                mul_b = dd2_reg;
            end
            2'd1: begin
                mul_a = MUL_W'(coef_b_reg);
                mul_b = dd4_reg;
            end
            2'd2: begin
                mul_a = y64_reg;
                mul_b = cq_reg;
            end
            default: begin
                mul_a = x64_reg;
                mul_b = cq_reg;
            end
        endcase
    end

    rdsf_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    // C in Q96 is A*D2*2^44 + B*D4; its upper half is C in Q32, floored.
    logic [PROD_W-1:0] c_sum;
    // Target in Q32: position minus offset times C. A value in (-1, 0)
    // truncates to zero; any other negative value, or one at or beyond the
    // limit, falls outside the frame.
    logic [PROD_W-1:0] tgt_v;
    logic [31:0]       tgt_limit;
    logic              tgt_zero, tgt_in, tgt_ok;

    always_comb begin
        c_sum = (ta_reg << 44) + mul_prod;
        if (op_reg == 2'd2) begin
            tgt_v     = (PROD_W'(cur_row_reg) << 32) - mul_prod;
            tgt_limit = 32'(rows_eff);
        end else begin
            tgt_v     = (PROD_W'(cur_col_reg) << 32) - mul_prod;
            tgt_limit = 32'(cols_eff);
        end
        tgt_zero = tgt_v[PROD_W-1] && (&tgt_v[PROD_W-1:32]) && (|tgt_v[31:0]);
        tgt_in   = !tgt_v[PROD_W-1] && (tgt_v[PROD_W-1:64] == '0)
                   && (tgt_v[63:32] < tgt_limit);
        tgt_ok   = tgt_zero || tgt_in;
    end

    // Neighbor selection for the repair of a black pixel.
    logic          nb_ok;
    logic [AW-1:0] nb_addr;
    logic [AW-1:0] ctr_addr;

    assign ctr_addr = {cur_row_reg, cur_col_reg};

    always_comb begin
        case (nb_reg)
            2'd0: begin
                nb_ok   = cur_row_reg != '0;
                nb_addr = {cur_row_reg - 1'b1, cur_col_reg};
            end
            2'd1: begin
                nb_ok   = (RN'(cur_row_reg) + 1'b1) < rows_eff;
                nb_addr = {cur_row_reg + 1'b1, cur_col_reg};
            end
            2'd2: begin
                nb_ok   = cur_col_reg != '0;
                nb_addr = {cur_row_reg, cur_col_reg - 1'b1};
            end
            default: begin
                nb_ok   = (CN'(cur_col_reg) + 1'b1) < cols_eff;
                nb_addr = {cur_row_reg, cur_col_reg + 1'b1};
            end
        endcase
    end

    // Mean of n non-black neighbors, rounded half up: (2*sum + n) / (2*n).
    function automatic logic [7:0] fill_mean(input logic [9:0] sum, input logic [2:0] n);
        logic [10:0] v;
        logic [24:0] p;
        v = '0;
        p = '0;
        case (n)
            3'd1: fill_mean = sum[7:0];
            3'd2: begin
                v = 11'(sum) + 11'd1;
                fill_mean = v[8:1];
            end
            3'd3: begin
                v = {sum, 1'b0} + 11'd3;
                p = 25'(v) * 25'(RECIP_DIV6);
                fill_mean = p[SHIFT_DIV6 +: 8];
            end
            3'd4: begin
                v = 11'(sum) + 11'd2;
                fill_mean = v[9:2];
            end
            default: fill_mean = 8'd0;
        endcase
    endfunction

    logic [PIX_W-1:0] fill_px;
    assign fill_px = {fill_mean(sum_r_reg, nb_cnt_reg),
                      fill_mean(sum_g_reg, nb_cnt_reg),
                      fill_mean(sum_b_reg, nb_cnt_reg)};

    // Store.
    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [PIX_W-1:0] mem_wdata, mem_rdata;

    rdsf_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    logic s_fire;
    logic out_load;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_load = (state_reg == ST_R_OUT) && (!m_valid_reg || m_ready);

    // Next state and control outputs.
    always_comb begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = ctr_addr;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = ctr_addr;
        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                if (clr_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_data.req_type)
                        REQ_CLEAR: state_next = ST_CLEAR;
                        REQ_LOAD:  state_next = ST_L_SQ;
                        REQ_READ:  state_next = ST_R_CTR;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_L_SQ:  state_next = ST_L_SQ2;
            ST_L_SQ2: state_next = ST_L_MGO;
            ST_L_MGO: begin
                mul_start  = 1'b1;
                state_next = ST_L_MWAIT;
            end
            ST_L_MWAIT: begin
                if (mul_done) begin
                    state_next = (op_reg == 2'd3) ? ST_L_WR : ST_L_MGO;
                end
            end
            ST_L_WR: begin
                mem_we     = tr_ok_reg && tc_ok_reg;
                mem_waddr  = {tr_reg, tc_reg};
                mem_wdata  = pix_reg;
                state_next = ST_IDLE;
            end
            ST_R_CTR: begin
                mem_re     = 1'b1;
                state_next = ST_R_CTRW;
            end
            ST_R_CTRW: begin
                state_next = (mem_rdata != '0) ? ST_R_OUT : ST_R_NB;
            end
            ST_R_NB: begin
                if (nb_ok) begin
                    mem_re     = 1'b1;
                    mem_raddr  = nb_addr;
                    state_next = ST_R_NBW;
                end else if (nb_reg == 2'd3) begin
                    state_next = ST_R_FILL;
                end
            end
            ST_R_NBW: begin
                state_next = (nb_reg == 2'd3) ? ST_R_FILL : ST_R_NB;
            end
            ST_R_FILL: begin
                // The repair goes back into the store, so later pixels see it.
                mem_we     = nb_cnt_reg != 3'd0;
                mem_wdata  = fill_px;
                state_next = ST_R_OUT;
            end
            ST_R_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            load_row_reg <= '0;
            load_col_reg <= '0;
            read_row_reg <= '0;
            read_col_reg <= '0;
            op_reg       <= '0;
            nb_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (s_fire) begin
                case (s_data.req_type)
                    REQ_CLEAR: begin
                        clr_addr_reg <= '0;
                        load_row_reg <= '0;
                        load_col_reg <= '0;
                        read_row_reg <= '0;
                        read_col_reg <= '0;
                    end
                    REQ_LOAD: begin
                        load_row_reg <= lrow_adv;
                        load_col_reg <= lcol_adv;
                        read_row_reg <= rrow_n;
                        read_col_reg <= rcol_n;
                        op_reg       <= '0;
                    end
                    REQ_READ: begin
                        load_row_reg <= lrow_n;
                        load_col_reg <= lcol_n;
                        read_row_reg <= rrow_adv;
                        read_col_reg <= rcol_adv;
                        nb_reg       <= '0;
                    end
                    default: begin
                        load_row_reg <= lrow_n;
                        load_col_reg <= lcol_n;
                        read_row_reg <= rrow_n;
                        read_col_reg <= rcol_n;
                    end
                endcase
            end
            if (state_reg == ST_L_MWAIT && mul_done) begin
                op_reg <= op_reg + 1'b1;
            end
            if ((state_reg == ST_R_NB && !nb_ok) || state_reg == ST_R_NBW) begin
                nb_reg <= nb_reg + 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pix_reg <= {s_data.in_red, s_data.in_green, s_data.in_blue};
            if (s_data.req_type == REQ_READ) begin
                cur_row_reg  <= rrow_n;
                cur_col_reg  <= rcol_n;
                cur_last_reg <= r_last;
            end else begin
                cur_row_reg  <= lrow_n;
                cur_col_reg  <= lcol_n;
                cur_last_reg <= 1'b0;
            end
        end
        if (state_reg == ST_L_SQ) begin
            x64_reg <= MUL_W'(x_s);
            y64_reg <= MUL_W'(y_s);
            d2_reg  <= D2W'($unsigned(sqx)) + D2W'($unsigned(sqy));
            r2_reg  <= r2_c;
        end
        if (state_reg == ST_L_SQ2) begin
            dd2_reg <= (MUL_W'(d2_reg) << 8) - MUL_W'(r2_reg);
            dd4_reg <= (MUL_W'(d2sq) << 16) - MUL_W'(r4);
        end
        if (state_reg == ST_L_MWAIT && mul_done) begin
            case (op_reg)
                2'd0: ta_reg <= mul_prod;
                2'd1: cq_reg <= c_sum[PROD_W-1:64];
                2'd2: begin
                    tr_ok_reg <= tgt_ok;
                    tr_reg    <= tgt_zero ? '0 : tgt_v[32 +: RA];
                end
                default: begin
                    tc_ok_reg <= tgt_ok;
                    tc_reg    <= tgt_zero ? '0 : tgt_v[32 +: CA];
                end
            endcase
        end
        if (state_reg == ST_R_CTRW) begin
            res_px_reg <= mem_rdata;
            sum_b_reg  <= '0;
            sum_g_reg  <= '0;
            sum_r_reg  <= '0;
            nb_cnt_reg <= '0;
        end
        if (state_reg == ST_R_NBW && mem_rdata != '0) begin
            sum_b_reg  <= sum_b_reg + 10'(mem_rdata[7:0]);
            sum_g_reg  <= sum_g_reg + 10'(mem_rdata[15:8]);
            sum_r_reg  <= sum_r_reg + 10'(mem_rdata[23:16]);
            nb_cnt_reg <= nb_cnt_reg + 1'b1;
        end
        if (state_reg == ST_R_FILL && nb_cnt_reg != 3'd0) begin
            res_px_reg <= fill_px;
        end
        if (out_load) begin
            m_data_reg.out_blue   <= res_px_reg[7:0];
            m_data_reg.out_green  <= res_px_reg[15:8];
            m_data_reg.out_red    <= res_px_reg[23:16];
            m_data_reg.last_pixel <= cur_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A store write happens only in the clear pass, a load write or a repair.
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("store written while idle");

    // The multiplier reports completion only to a waiting load.
    a_mul_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> (state_reg == ST_L_MWAIT))
        else $error("multiplier done outside of its wait state");

    // A scattered pixel lands inside the frame in use.
    a_target_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_L_WR && mem_we) |->
            ((RN'(tr_reg) < rows_eff) && (CN'(tc_reg) < cols_eff)))
        else $error("load target outside the frame");

    // A finished read always shows up on the result channel.
    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg)
        else $error("read result not presented");

endmodule
